// File: hdl/text_console_char_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_char_writer_assert
// Assertion macros shared by the console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tccw: check failed");

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tccw: check failed");

`endif

// File: hdl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int POS_W  = 11;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;

   localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
   localparam logic [3:0]        TEXT_RESET   = 4'd7;
   localparam logic [3:0]        BG_RESET     = 4'd0;

   typedef enum logic [1:0] {
      MODE_PRINT,
      MODE_SET_CURSOR,
      MODE_CLEAR,
      MODE_READ
   } mode_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_RESULT
   } state_type;

   typedef enum logic {
      CSR_TEXT_COLOUR,
      CSR_BG_COLOUR
   } csr_index_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic              scroll;
      logic              home;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] wdata;
   } store_req_type;

endpackage

// File: hdl/tccw_cell_store.sv
// ----------------------------------------------------------------------------
// tccw_cell_store
// Cell memory with a rotating top-row pointer for one-line scrolls.
// ----------------------------------------------------------------------------
module tccw_cell_store #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tccw_pkg::store_req_type      store_req,
   output logic [tccw_pkg::CELL_W-1:0]  store_rdata
);

   localparam int DEPTH = COLUMNS * ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = tccw_pkg::ROW_W;
   localparam logic [RW:0]   ROWS_S   = (RW+1)'(ROWS);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

   logic [tccw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tccw_pkg::CELL_W-1:0] rdata_ff;
   logic [RW-1:0]               top_ff;
   logic [RW-1:0]               top_in;
   logic [RW:0]                 phys_sum;
   logic [RW:0]                 phys_wrap;
   logic [RW-1:0]               phys_row;
   logic [AW-1:0]               addr;

   assign phys_sum  = {1'b0, store_req.row} + {1'b0, top_ff};
   assign phys_wrap = (phys_sum >= ROWS_S) ? (phys_sum - ROWS_S) : phys_sum;
   assign phys_row  = phys_wrap[RW-1:0];
   assign addr      = AW'(phys_row) * COLS_A + AW'(store_req.col);

   always_comb begin
      top_in = top_ff;
      if (store_req.home) begin
         top_in = '0;
      end else if (store_req.scroll) begin
         top_in = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[addr] <= store_req.wdata;
      end
      if (store_req.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign store_rdata = rdata_ff;

endmodule

// File: hdl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl
// Command sequencer: cursor, fill sweeps and the result word register.
// ----------------------------------------------------------------------------
module tccw_ctrl #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [3:0]                    text_colour,
   input  logic [3:0]                    bg_colour,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  tccw_pkg::mode_type            req_mode,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char,
   input  logic [tccw_pkg::COL_W-1:0]    req_col,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row,
   output tccw_pkg::store_req_type       store_req,
   input  logic [tccw_pkg::CELL_W-1:0]   store_rdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tccw_pkg::COL_W-1:0]    rsp_col,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_row,
   output logic [tccw_pkg::POS_W-1:0]    rsp_pos,
   output logic                          rsp_scrolled,
   output logic [tccw_pkg::CHAR_W-1:0]   rsp_char,
   output logic [tccw_pkg::ATTR_W-1:0]   rsp_attr
);

   localparam int CW = tccw_pkg::COL_W;
   localparam int RW = tccw_pkg::ROW_W;
   localparam int PW = CW + RW + 1;
   localparam logic [CW:0]   COLS_S   = (CW+1)'(COLUMNS);
   localparam logic [RW:0]   ROWS_S   = (RW+1)'(ROWS);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [PW-1:0] COLS_P   = PW'(COLUMNS);

   tccw_pkg::state_type state_ff, state_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     fill_col_ff, fill_col_in;
   logic [RW-1:0]     fill_row_ff, fill_row_in;
   logic [tccw_pkg::ATTR_W-1:0] fill_attr_ff, fill_attr_in;
   logic              fill_pend_ff, fill_pend_in;
   logic              scrolled_ff, scrolled_in;
   logic              rd_hit_ff, rd_hit_in;
   logic              rsp_tvalid_ff;
   logic [CW-1:0]     rsp_col_ff;
   logic [RW-1:0]     rsp_row_ff;
   logic [tccw_pkg::POS_W-1:0]  rsp_pos_ff;
   logic              rsp_scrolled_ff;
   logic [tccw_pkg::CHAR_W-1:0] rsp_char_ff;
   logic [tccw_pkg::ATTR_W-1:0] rsp_attr_ff;

   logic              rsp_load;
   logic [CW:0]       col_inc;
   logic [CW:0]       col_next;
   logic [RW:0]       row_inc;
   logic              tgt_ok;
   logic              cur_ok;
   logic              is_nl;
   logic [tccw_pkg::ATTR_W-1:0] new_attr;
   logic [PW-1:0]     pos_full;

   assign pos_full = PW'(cur_row_ff) * COLS_P + PW'(cur_col_ff);

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      fill_col_in  = fill_col_ff;
      fill_row_in  = fill_row_ff;
      fill_attr_in = fill_attr_ff;
      fill_pend_in = fill_pend_ff;
      scrolled_in  = scrolled_ff;
      rd_hit_in    = rd_hit_ff;
      store_req    = '0;
      rsp_load     = 1'b0;
      col_inc  = {1'b0, cur_col_ff} + 1'b1;
      row_inc  = {1'b0, cur_row_ff} + 1'b1;
      new_attr = {bg_colour, text_colour};
      tgt_ok   = ({1'b0, req_col} < COLS_S) && ({1'b0, req_row} < ROWS_S);
      cur_ok   = ({1'b0, cur_col_ff} < COLS_S) && ({1'b0, cur_row_ff} < ROWS_S);
      is_nl    = (req_char == tccw_pkg::NEWLINE_CHAR);
      col_next = is_nl ? {1'b0, cur_col_ff} : col_inc;

      case (state_ff)
         tccw_pkg::ST_FILL: begin
            store_req.wr_en = 1'b1;
            store_req.row   = fill_row_ff;
            store_req.col   = fill_col_ff;
            store_req.wdata = {fill_attr_ff, tccw_pkg::SPACE_CHAR};
            if (fill_col_ff == LAST_COL) begin
               fill_col_in = '0;
               if (fill_row_ff == LAST_ROW) begin
                  fill_pend_in = 1'b0;
                  state_in     = tccw_pkg::ST_IDLE;
               end else begin
                  fill_row_in = fill_row_ff + 1'b1;
               end
            end else begin
               fill_col_in = fill_col_ff + 1'b1;
            end
         end
         tccw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in     = tccw_pkg::ST_RESULT;
               scrolled_in  = 1'b0;
               rd_hit_in    = 1'b0;
               fill_pend_in = 1'b0;
               fill_attr_in = new_attr;
               fill_col_in  = '0;
               case (req_mode)
                  tccw_pkg::MODE_PRINT: begin
                     if (!cur_ok) begin
                        cur_col_in = '0;
                        cur_row_in = '0;
                     end else begin
                        store_req.wr_en = !is_nl;
                        store_req.row   = cur_row_ff;
                        store_req.col   = cur_col_ff;
                        store_req.wdata = {new_attr, req_char};
                        if (is_nl || (col_next >= COLS_S)) begin
                           cur_col_in = '0;
                           if (row_inc >= ROWS_S) begin
                              cur_row_in       = LAST_ROW;
                              scrolled_in      = 1'b1;
                              fill_pend_in     = 1'b1;
                              fill_row_in      = LAST_ROW;
                              store_req.scroll = 1'b1;
                           end else begin
                              cur_row_in = row_inc[RW-1:0];
                           end
                        end else begin
                           cur_col_in = col_next[CW-1:0];
                        end
                     end
                  end
                  tccw_pkg::MODE_SET_CURSOR: begin
                     if (tgt_ok) begin
                        cur_col_in = req_col;
                        cur_row_in = req_row;
                     end
                  end
                  tccw_pkg::MODE_CLEAR: begin
                     cur_col_in     = '0;
                     cur_row_in     = '0;
                     store_req.home = 1'b1;
                     fill_pend_in   = 1'b1;
                     fill_row_in    = '0;
                  end
                  tccw_pkg::MODE_READ: begin
                     store_req.rd_en = tgt_ok;
                     store_req.row   = req_row;
                     store_req.col   = req_col;
                     rd_hit_in       = tgt_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tccw_pkg::ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = fill_pend_ff ? tccw_pkg::ST_FILL : tccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tccw_pkg::ST_FILL;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         fill_col_ff   <= '0;
         fill_row_ff   <= '0;
         fill_attr_ff  <= {tccw_pkg::BG_RESET, tccw_pkg::TEXT_RESET};
         fill_pend_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         fill_col_ff   <= fill_col_in;
         fill_row_ff   <= fill_row_in;
         fill_attr_ff  <= fill_attr_in;
         fill_pend_ff  <= fill_pend_in;
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scrolled_ff <= scrolled_in;
      rd_hit_ff   <= rd_hit_in;
      if (rsp_load) begin
         rsp_col_ff      <= cur_col_ff;
         rsp_row_ff      <= cur_row_ff;
         rsp_pos_ff      <= pos_full[tccw_pkg::POS_W-1:0];
         rsp_scrolled_ff <= scrolled_ff;
         rsp_char_ff     <= rd_hit_ff ? store_rdata[tccw_pkg::CHAR_W-1:0] : '0;
         rsp_attr_ff     <= rd_hit_ff ? store_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W]
                                      : '0;
      end
   end

   assign req_tready   = (state_ff == tccw_pkg::ST_IDLE);
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_col      = rsp_col_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_pos      = rsp_pos_ff;
   assign rsp_scrolled = rsp_scrolled_ff;
   assign rsp_char     = rsp_char_ff;
   assign rsp_attr     = rsp_attr_ff;

endmodule

// File: hdl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console: cell store, cursor and colour registers.
// ----------------------------------------------------------------------------
// The req stream carries one command word: print, set cursor, clear or read
// cell (mode in req_tuser). Every command returns one rsp word with the
// cursor after the command, its linear position, the scroll flag and, for a
// read, the addressed cell.
// For a plain command the word is accepted and the cell store is written or
// read in that cycle; the result word then passes through the result state
// into the output register, and the block is ready again once it is loaded.
// A print that scrolls then blanks the new bottom line and a clear blanks the
// whole store, one cell write per cycle on the single memory port. Scrolling
// rotates a top-row pointer; no line is copied.
// After reset the store is blanked with spaces in attribute 0x07 while
// req_tready is held low.
// When the rsp side stalls, the result word holds in the output register and
// the next command waits one step behind it.
// The colour registers sit at byte addresses 0 (text) and 4 (background).
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], target_col[14:8], target_row[19:15], zero fill
   input  logic [23:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_position[22:12],
   // scrolled[23], read_char[31:24], read_attr[39:32]
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "text_console_char_writer_assert.svh"

   tccw_pkg::store_req_type       store_req;
   logic [tccw_pkg::CELL_W-1:0]   store_rdata;
   logic [3:0]                    text_colour_ff;
   logic [3:0]                    bg_colour_ff;
   logic                          csr_wr;
   tccw_pkg::csr_index_type       csr_index;
   logic [tccw_pkg::COL_W-1:0]    rsp_col;
   logic [tccw_pkg::ROW_W-1:0]    rsp_row;
   logic [tccw_pkg::POS_W-1:0]    rsp_pos;
   logic                          rsp_scrolled;
   logic [tccw_pkg::CHAR_W-1:0]   rsp_char;
   logic [tccw_pkg::ATTR_W-1:0]   rsp_attr;
   logic                          rsp_scroll_ok;
   logic                          rsp_range_ok;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = tccw_pkg::csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         text_colour_ff <= tccw_pkg::TEXT_RESET;
         bg_colour_ff   <= tccw_pkg::BG_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            tccw_pkg::CSR_TEXT_COLOUR: text_colour_ff <= csr_pwdata[3:0];
            tccw_pkg::CSR_BG_COLOUR:   bg_colour_ff   <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tccw_pkg::CSR_TEXT_COLOUR: csr_prdata = {28'd0, text_colour_ff};
         tccw_pkg::CSR_BG_COLOUR:   csr_prdata = {28'd0, bg_colour_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   tccw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .text_colour  (text_colour_ff),
      .bg_colour    (bg_colour_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_mode     (tccw_pkg::mode_type'(req_tuser)),
      .req_char     (req_tdata[7:0]),
      .req_col      (req_tdata[14:8]),
      .req_row      (req_tdata[19:15]),
      .store_req    (store_req),
      .store_rdata  (store_rdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_col      (rsp_col),
      .rsp_row      (rsp_row),
      .rsp_pos      (rsp_pos),
      .rsp_scrolled (rsp_scrolled),
      .rsp_char     (rsp_char),
      .rsp_attr     (rsp_attr)
   );

   tccw_cell_store #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .store_req   (store_req),
      .store_rdata (store_rdata)
   );

   assign rsp_tdata = {rsp_attr, rsp_char, rsp_scrolled, rsp_pos, rsp_row, rsp_col};

   assign rsp_scroll_ok = (rsp_col == '0) && (rsp_row == tccw_pkg::ROW_W'(ROWS - 1));
   assign rsp_range_ok  = (32'(rsp_col) < COLUMNS) && (32'(rsp_row) < ROWS);

   `TCCW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `TCCW_ASSERT_IMPLY(a_fill_after_reset, clock, reset, $past(reset), !req_tready)
   `TCCW_ASSERT_IMPLY(a_scroll_cursor, clock, reset, rsp_tvalid && rsp_scrolled, rsp_scroll_ok)
   `TCCW_ASSERT_IMPLY(a_cursor_range, clock, reset, rsp_tvalid, rsp_range_ok)

endmodule
